@@ src/vssc_pkg.sv @@
// ----------------------------------------------------------------------------
// vssc_pkg - scaler setup calculator shared definitions
// register indexes and reset values of the configuration registers, fraction bits and lane count
// ----------------------------------------------------------------------------
package vssc_pkg;

	typedef enum logic [2:0] {
		CFG_SCREEN_WIDTH    = 3'd0,
		CFG_SCREEN_HEIGHT   = 3'd1,
		CFG_DEST_LINE_BYTES = 3'd2,
		CFG_PIXEL_BITS      = 3'd3,
		CFG_DEST_BASE       = 3'd4
	} cfg_idx_t;

	localparam logic [11:0] RST_SCREEN_WIDTH    = 12'd800;
	localparam logic [11:0] RST_SCREEN_HEIGHT   = 12'd480;
	localparam logic [15:0] RST_DEST_LINE_BYTES = 16'd1600;
	localparam logic [5:0]  RST_PIXEL_BITS      = 6'd16;
	localparam logic [31:0] RST_DEST_BASE       = 32'd0;

	localparam int FRAC_BITS = 12;
	localparam int LANES     = 6;

endpackage

@@ src/vssc_cell.sv @@
// ----------------------------------------------------------------------------
// vssc_cell - one restoring division step
// takes one numerator bit into the partial remainder of each lane
// ----------------------------------------------------------------------------
module vssc_cell
	import vssc_pkg::*;
#(
	parameter int NW     = 24,
	parameter int DW     = 13,
	parameter int SIDE_W = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_i,
	input  logic [LANES-1:0][NW-1:0]       num_i,
	input  logic [LANES-1:0][DW-1:0]       rem_i,
	input  logic [LANES-1:0][NW-1:0]       quo_i,
	input  logic [LANES-1:0][DW-1:0]       den_i,
	input  logic [SIDE_W-1:0]              side_i,
	output logic                           valid_o,
	output logic [LANES-1:0][NW-1:0]       num_o,
	output logic [LANES-1:0][DW-1:0]       rem_o,
	output logic [LANES-1:0][NW-1:0]       quo_o,
	output logic [LANES-1:0][DW-1:0]       den_o,
	output logic [SIDE_W-1:0]              side_o
);

	logic                       valid_q;
	logic [LANES-1:0][NW-1:0]   num_q;
	logic [LANES-1:0][DW-1:0]   rem_q;
	logic [LANES-1:0][NW-1:0]   quo_q;
	logic [LANES-1:0][DW-1:0]   den_q;
	logic [SIDE_W-1:0]          side_q;
	logic [LANES-1:0][DW-1:0]   rem_nx;
	logic [LANES-1:0]           qbit;

	always_comb begin
		logic [DW:0] r2;
		for (int l = 0; l < LANES; l++) begin
			r2 = {rem_i[l], num_i[l][NW-1]};
			qbit[l] = (r2 >= {1'b0, den_i[l]});
			if (qbit[l]) begin
				r2 = r2 - {1'b0, den_i[l]};
			end
			rem_nx[l] = r2[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			num_q[l] <= {num_i[l][NW-2:0], 1'b0};
			quo_q[l] <= {quo_i[l][NW-2:0], qbit[l]};
		end
		rem_q  <= rem_nx;
		den_q  <= den_i;
		side_q <= side_i;
	end

	assign valid_o = valid_q;
	assign num_o   = num_q;
	assign rem_o   = rem_q;
	assign quo_o   = quo_q;
	assign den_o   = den_q;
	assign side_o  = side_q;

endmodule

@@ src/vssc_chain.sv @@
// ----------------------------------------------------------------------------
// vssc_chain - row of division cells
// one quotient bit per cell, all lanes advance together each cycle
// ----------------------------------------------------------------------------
module vssc_chain
	import vssc_pkg::*;
#(
	parameter int NW     = 24,
	parameter int DW     = 13,
	parameter int SIDE_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_i,
	input  logic [LANES-1:0][NW-1:0]  num_i,
	input  logic [LANES-1:0][DW-1:0]  den_i,
	input  logic [SIDE_W-1:0]         side_i,
	output logic                      valid_o,
	output logic [LANES-1:0][NW-1:0]  quo_o,
	output logic [SIDE_W-1:0]         side_o
);

	logic                      v_w    [NW+1];
	logic [LANES-1:0][NW-1:0]  num_w  [NW+1];
	logic [LANES-1:0][DW-1:0]  rem_w  [NW+1];
	logic [LANES-1:0][NW-1:0]  quo_w  [NW+1];
	logic [LANES-1:0][DW-1:0]  den_w  [NW+1];
	logic [SIDE_W-1:0]         side_w [NW+1];

	assign v_w[0]    = valid_i;
	assign num_w[0]  = num_i;
	assign rem_w[0]  = '0;
	assign quo_w[0]  = '0;
	assign den_w[0]  = den_i;
	assign side_w[0] = side_i;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		vssc_cell #(.NW(NW), .DW(DW), .SIDE_W(SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (v_w[k]),
			.num_i   (num_w[k]),
			.rem_i   (rem_w[k]),
			.quo_i   (quo_w[k]),
			.den_i   (den_w[k]),
			.side_i  (side_w[k]),
			.valid_o (v_w[k+1]),
			.num_o   (num_w[k+1]),
			.rem_o   (rem_w[k+1]),
			.quo_o   (quo_w[k+1]),
			.den_o   (den_w[k+1]),
			.side_o  (side_w[k+1])
		);
	end

	assign valid_o = v_w[NW];
	assign quo_o   = quo_w[NW];
	assign side_o  = side_w[NW];

endmodule

@@ src/video_scaler_setup_calc.sv @@
// ----------------------------------------------------------------------------
// video_scaler_setup_calc - scaler register word calculator
// crops the target, derives scale, clip, size, stride and address words
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  command   start, busy, source_*, target_*, position_* in
//  result    done, scale_word .. error                 out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
//  one item per cycle; each result passes stage 1, stage 2, the row of
//  division cells (one quotient bit per cell) and the output register
//  busy is always low and cfg_ready always high
//  reset clears the pipeline valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module video_scaler_setup_calc
	import vssc_pkg::*;
#(
	parameter int SIZE_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SIZE_BITS-1:0] source_width,
	input  logic [SIZE_BITS-1:0] source_height,
	input  logic [SIZE_BITS-1:0] target_width,
	input  logic [SIZE_BITS-1:0] target_height,
	input  logic [SIZE_BITS-1:0] position_x,
	input  logic [SIZE_BITS-1:0] position_y,
	output logic                 done,
	output logic [31:0]          scale_word,
	output logic [31:0]          clip_word,
	output logic [12:0]          source_stride,
	output logic [31:0]          source_size_word,
	output logic [31:0]          dest_address,
	output logic                 error,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int SB     = SIZE_BITS;
	localparam int NW     = (SB + FRAC_BITS > 2 * SB) ? SB + FRAC_BITS : 2 * SB;
	localparam int DW     = SB + 1;
	localparam int SIDE_W = 6 * SB + 13 + 32 + 1;
	localparam int LAT    = NW + 3;
	localparam int CW     = ((SB > 12) ? SB : 12) + 1;

	// configuration
	logic [11:0] scr_w_q, scr_h_q;
	logic [15:0] line_q;
	logic [5:0]  pbits_q;
	logic [31:0] base_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= RST_SCREEN_WIDTH;
			scr_h_q <= RST_SCREEN_HEIGHT;
			line_q  <= RST_DEST_LINE_BYTES;
			pbits_q <= RST_PIXEL_BITS;
			base_q  <= RST_DEST_BASE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:    scr_w_q <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT:   scr_h_q <= cfg_data[11:0];
				CFG_DEST_LINE_BYTES: line_q  <= cfg_data[15:0];
				CFG_PIXEL_BITS:      pbits_q <= cfg_data[5:0];
				CFG_DEST_BASE:       base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: crop, stride, address, error flag
	function automatic logic [SB-1:0] crop_f(input logic [SB-1:0] size,
		input logic [SB-1:0] pos, input logic [11:0] lim);
		logic [CW-1:0] sum;
		logic [CW-1:0] limx;
		logic [CW-1:0] posx;
		logic [CW-1:0] diff;
		posx = CW'(pos);
		sum  = CW'(size) + posx;
		limx = CW'(lim);
		diff = limx - posx;
		if (sum > limx) begin
			crop_f = (limx > posx) ? diff[SB-1:0] : '0;
		end else begin
			crop_f = size;
		end
	endfunction

	logic          v_s1;
	logic [SB-1:0] sw_s1, sh_s1, tw_s1, th_s1, cw_s1, ch_s1;
	logic [12:0]   stride_s1;
	logic [31:0]   addr_s1;
	logic          err_s1;
	logic [SB-1:0] px_al;
	logic [SB+4:0] stride_sum;

	assign px_al      = position_x & ~SB'(3);
	assign stride_sum = (SB + 5)'(source_width) + (SB + 5)'(15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sw_s1     <= source_width;
		sh_s1     <= source_height;
		tw_s1     <= target_width;
		th_s1     <= target_height;
		cw_s1     <= crop_f(target_width, px_al, scr_w_q);
		ch_s1     <= crop_f(target_height, position_y, scr_h_q);
		stride_s1 <= stride_sum[12:0] & ~13'd15;
		err_s1    <= (target_width == '0) || (target_height == '0);
		addr_s1   <= base_q + 32'(px_al) * 32'(pbits_q[5:3])
			+ 32'(position_y) * 32'(line_q);
	end

	// stage 2: numerators and divisors
	logic                     v_s2;
	logic [LANES-1:0][NW-1:0] num_s2;
	logic [LANES-1:0][DW-1:0] den_s2;
	logic [SIDE_W-1:0]        side_s2;

	function automatic logic [SB-1:0] dec_f(input logic [SB-1:0] x);
		dec_f = (x != '0) ? x - SB'(1) : '0;
	endfunction

	function automatic logic [DW-1:0] nz_f(input logic [SB-1:0] x);
		nz_f = (x != '0) ? {1'b0, x} : DW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2[0] <= NW'(sw_s1) << FRAC_BITS;
		num_s2[1] <= NW'(dec_f(sw_s1)) << FRAC_BITS;
		num_s2[2] <= NW'(sw_s1) * NW'(cw_s1);
		num_s2[3] <= NW'(sh_s1) << FRAC_BITS;
		num_s2[4] <= NW'(dec_f(sh_s1)) << FRAC_BITS;
		num_s2[5] <= NW'(sh_s1) * NW'(ch_s1);
		den_s2[0] <= nz_f(tw_s1);
		den_s2[1] <= {1'b0, tw_s1} + DW'(1);
		den_s2[2] <= nz_f(tw_s1);
		den_s2[3] <= nz_f(th_s1);
		den_s2[4] <= {1'b0, th_s1} + DW'(1);
		den_s2[5] <= nz_f(th_s1);
		side_s2   <= {sw_s1, sh_s1, tw_s1, th_s1, cw_s1, ch_s1, stride_s1, addr_s1, err_s1};
	end

	// division row
	logic                     v_dv;
	logic [LANES-1:0][NW-1:0] quo_dv;
	logic [SIDE_W-1:0]        side_dv;

	vssc_chain #(.NW(NW), .DW(DW), .SIDE_W(SIDE_W)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (v_s2),
		.num_i   (num_s2),
		.den_i   (den_s2),
		.side_i  (side_s2),
		.valid_o (v_dv),
		.quo_o   (quo_dv),
		.side_o  (side_dv)
	);

	logic [SB-1:0] sw_d, sh_d, tw_d, th_d, cw_d, ch_d;
	logic [12:0]   stride_d;
	logic [31:0]   addr_d;
	logic          err_d;

	assign {sw_d, sh_d, tw_d, th_d, cw_d, ch_d, stride_d, addr_d, err_d} = side_dv;

	typedef struct packed {
		logic [15:0] scale;
		logic [15:0] clip;
		logic [15:0] clipped;
	} axis_t;

	function automatic axis_t axis_f(input logic [SB-1:0] in_sz,
		input logic [SB-1:0] out_sz, input logic [SB-1:0] crop,
		input logic [NW-1:0] q0, input logic [NW-1:0] q1, input logic [NW-1:0] q2);
		axis_t       r;
		logic [3:0]  mant;
		logic [12:0] frac;
		logic [2:0]  rep;
		logic [11:0] f0;
		logic [15:0] csum;
		mant = '0;
		frac = '0;
		rep  = '0;
		f0   = q0[11:0] & ~12'h007;
		if (in_sz == out_sz) begin
			mant = {3'b000, crop != out_sz};
		end else begin
			if (out_sz > in_sz) begin
				if (f0 == 12'h800) begin
					rep = 3'd1;
				end else if (f0 == 12'h400) begin
					rep = 3'd3;
				end else if (f0 == 12'h200) begin
					rep = 3'd7;
				end
			end
			if (rep != '0) begin
				mant = q0[15:12];
				frac = {1'b0, f0};
			end else begin
				mant = q1[15:12];
				frac = {1'b0, q1[11:0]};
				if (frac[2:0] != '0) begin
					frac = frac & ~13'h0007;
					if (out_sz > in_sz) begin
						frac = (frac >= 13'd8) ? frac - 13'd8 : '0;
					end else begin
						frac = frac + 13'd8;
					end
				end
			end
		end
		csum      = q2[15:0] + 16'd3;
		r.scale   = {mant, 12'h000} | {3'b000, frac};
		r.clip    = (16'(rep) << 12) | 16'(crop);
		r.clipped = csum & ~16'd3;
		axis_f    = r;
	endfunction

	axis_t ha, va;

	assign ha = axis_f(sw_d, tw_d, cw_d, quo_dv[0], quo_dv[1], quo_dv[2]);
	assign va = axis_f(sh_d, th_d, ch_d, quo_dv[3], quo_dv[4], quo_dv[5]);

	// output register
	logic        done_q, err_q;
	logic [31:0] scale_q, clip_q, size_q, addr_q;
	logic [12:0] stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		err_q    <= err_d;
		scale_q  <= err_d ? '0 : {va.scale, ha.scale};
		clip_q   <= err_d ? '0 : {va.clip, ha.clip};
		size_q   <= err_d ? '0 : {va.clipped, ha.clipped};
		addr_q   <= err_d ? '0 : addr_d;
		stride_q <= err_d ? '0 : stride_d;
	end

	assign done             = done_q;
	assign error            = err_q;
	assign scale_word       = scale_q;
	assign clip_word        = clip_q;
	assign source_size_word = size_q;
	assign dest_address     = addr_q;
	assign source_stride    = stride_q;

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("result missing after start");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (scale_word == '0 && clip_word == '0 && dest_address == '0))
		else $error("error item carries data");
	a_stride: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (source_stride[3:0] == 4'd0)) else $error("stride not aligned");
	a_size_al: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (source_size_word[1:0] == 2'd0 && source_size_word[17:16] == 2'd0))
		else $error("clipped size not aligned");

endmodule
